// File: sv/ladlp_pkg.sv
// Shared constants, types and saturation helpers for the ladder low-pass filter.
`default_nettype none

package ladlp_pkg;

	// Fixed formats: samples Q1.15, state Q4.20, p Q0.18, feedback Q3.15 (unsigned)
	localparam int SAMPLE_W  = 16;
	localparam int STATE_W   = 24;
	localparam int COEF_W    = 18;
	localparam int MONO_W    = 21;
	localparam int MUL_W     = 32;
	localparam int PROD_W    = 64;
	localparam int ACC_W     = 48;
	localparam int SQ_W      = 28;
	localparam int MAG_W     = 30;
	localparam int QUOT_W    = 27;
	localparam int OUT_RND_W = 20;
	localparam int CFG_IDX_W = 2;
	localparam int STAGES    = 4;
	localparam int STAGE_IDX_W = 2;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd2;

	localparam logic              ENABLE_RST   = 1'b1;
	localparam logic [COEF_W-1:0] POLE_RST     = 18'd12226;
	localparam logic [COEF_W-1:0] FEEDBACK_RST = 18'd0;

	// ceil(2^32 / 6): exact truncating divide by six for magnitudes below 2^31
	localparam logic [MUL_W-1:0] RECIP6 = 32'd715827883;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FB_MUL,
		ST_FB_ADD,
		ST_SEC_A,
		ST_SEC_B,
		ST_SEC_ADD,
		ST_CLIP_SQ,
		ST_CLIP_SQR,
		ST_CLIP_CU,
		ST_CLIP_CUR,
		ST_CLIP_DIV,
		ST_CLIP_SUB,
		ST_OUT,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic              enable;
		logic [COEF_W-1:0] pole_coef;
		logic [COEF_W-1:0] feedback_coef;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       processed;
	} res_t;

	// Saturate a wide signed value to the state range
	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-STATE_W:0] top;
		top = v[ACC_W-1:STATE_W-1];
		if (top == '0 || top == '1) begin
			return v[STATE_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(STATE_W-1){1'b1}}};
		end
	endfunction

	// Saturate a rounded state value to the sample range
	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [OUT_RND_W-1:0] v);
		logic [OUT_RND_W-SAMPLE_W:0] top;
		top = v[OUT_RND_W-1:SAMPLE_W-1];
		if (top == '0 || top == '1) begin
			return v[SAMPLE_W-1:0];
		end else if (v[OUT_RND_W-1]) begin
			return {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

// File: sv/ladlp_in_if.sv
// Input sample channel: one stereo pair per request.
`default_nettype none

interface ladlp_in_if import ladlp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_in;
	logic signed [SAMPLE_W-1:0] right_in;

	modport source(output valid, left_in, right_in, input ready);
	modport sink(input valid, left_in, right_in, output ready);
endinterface

`default_nettype wire

// File: sv/ladlp_out_if.sv
// Output sample channel: one filtered or bypassed stereo pair per request.
`default_nettype none

interface ladlp_out_if import ladlp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic                       processed;

	modport source(output valid, left_out, right_out, processed, input ready);
	modport sink(input valid, left_out, right_out, processed, output ready);
endinterface

`default_nettype wire

// File: sv/ladlp_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface ladlp_cfg_if import ladlp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/ladder_lowpass_filter_unit.sv
// Top level of the four-pole ladder low-pass filter with its channels and registers.
//
// Usage:
//   in_ch  takes one stereo pair (left_in, right_in, Q1.15) per request.
//   out_ch gives one pair per input request (left_out, right_out, processed).
//   cfg_ch writes enable (index 0), pole_coef (1) and feedback_coef (2);
//   other indexes are dropped. Write only while the filter is idle.
// Sequencing:
//   A filtered request passes one product for feedback, two per section and
//   three in the clipper, all through one registered 32x32 multiplier, before
//   its result sits in the output register; a bypassed one goes straight there.
//   in_ch is ready only while the sequencer is idle, so a new request is taken
//   only once the last result has moved to the output register.
// Reset:
//   arst_n clears the section state to zero, restores register defaults
//   (enabled, p = 12226, no feedback) and empties the output register.
// Stall:
//   The output register holds a finished result while out_ch is stalled; the
//   next request is still taken and worked on, and holds in the sequencer
//   until the output register frees.
`default_nettype none

module ladder_lowpass_filter_unit import ladlp_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	ladlp_in_if.sink     in_ch,
	ladlp_out_if.source  out_ch,
	ladlp_cfg_if.sink    cfg_ch
);

	cfg_t  cfg_q;
	logic  core_ready;
	logic  start;
	logic  res_valid;
	logic  res_take;
	res_t  res;
	logic  out_valid_q;
	res_t  out_q;

	// Configuration registers: always ready, unknown indexes dropped
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= ENABLE_RST;
			cfg_q.pole_coef     <= POLE_RST;
			cfg_q.feedback_coef <= FEEDBACK_RST;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_ENABLE:   cfg_q.enable        <= cfg_ch.data[0];
				REG_POLE:     cfg_q.pole_coef     <= cfg_ch.data;
				REG_FEEDBACK: cfg_q.feedback_coef <= cfg_ch.data;
				default: begin
				end
			endcase
		end
	end

	// Accept a request whenever the sequencer is idle
	assign in_ch.ready = core_ready;
	assign start       = in_ch.valid && core_ready;

	ladlp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.left      (in_ch.left_in),
		.right     (in_ch.right_in),
		.ready     (core_ready),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// Output register: load a finished result when empty or being drained
	assign res_take = res_valid && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.left_out  = out_q.left;
	assign out_ch.right_out = out_q.right;
	assign out_ch.processed = out_q.processed;

endmodule

`default_nettype wire

// File: sv/ladlp_mul.sv
// Shared signed 32x32 multiplier with a registered product.
`default_nettype none

module ladlp_mul import ladlp_pkg::*; (
	input  wire logic                     clk,
	input  wire logic signed [MUL_W-1:0]  op_a,
	input  wire logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0]      prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

endmodule

`default_nettype wire

// File: sv/ladlp_core.sv
// Sequencer and filter state: runs feedback, four sections and the clipper on one multiplier.
`default_nettype none

module ladlp_core import ladlp_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cfg_t                       cfg,
	input  wire logic                       start,
	input  wire logic signed [SAMPLE_W-1:0] left,
	input  wire logic signed [SAMPLE_W-1:0] right,
	output logic                            ready,
	output logic                            res_valid,
	input  wire logic                       res_take,
	output res_t                            res
);

	seq_state_t state_q, state_d;

	logic signed [STATE_W-1:0]  stage_out_q  [STAGES];
	logic signed [STATE_W-1:0]  stage_prev_q [STAGES];
	logic [STAGE_IDX_W-1:0]     idx_q;
	logic signed [STATE_W-1:0]  stage_in_q;
	logic signed [MONO_W-1:0]   mono_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SQ_W-1:0]     sq_q;
	logic [MAG_W-1:0]           mag_q;
	logic                       neg_q;
	res_t                       res_q;

	logic signed [MUL_W-1:0]    op_a, op_b;
	logic signed [PROD_W-1:0]   prod_s1;

	logic signed [STATE_W-1:0]  so3;
	logic signed [ACC_W-1:0]    prod48;
	logic signed [ACC_W-1:0]    fb_rnd;
	logic signed [ACC_W-1:0]    mono48;
	logic signed [STATE_W-1:0]  x_next;
	logic signed [ACC_W-1:0]    sec_sum;
	logic signed [ACC_W-1:0]    sec_rnd;
	logic signed [STATE_W-1:0]  sec_y;
	logic signed [ACC_W-1:0]    sq_rnd;
	logic signed [PROD_W-1:0]   cube;
	logic signed [PROD_W-1:0]   cube_abs;
	logic [QUOT_W-1:0]          quot;
	logic signed [ACC_W-1:0]    term;
	logic signed [STATE_W-1:0]  clip_y;
	logic signed [STATE_W:0]    out_t;
	logic signed [STATE_W:0]    out_sh;
	logic signed [SAMPLE_W:0]   in_sum;

	ladlp_mul u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_s1 (prod_s1)
	);

	// Datapath arithmetic around the registered product
	always_comb begin
		so3     = stage_out_q[STAGES-1];
		prod48  = prod_s1[ACC_W-1:0];
		in_sum  = {left[SAMPLE_W-1], left} + {right[SAMPLE_W-1], right};
		fb_rnd  = (prod48 + 48'sd16384) >>> 15;
		mono48  = {{(ACC_W-MONO_W){mono_q[MONO_W-1]}}, mono_q};
		x_next  = sat_state(mono48 - fb_rnd);
		sec_sum = acc_q + prod48;
		sec_rnd = (sec_sum + 48'sd131072) >>> 18;
		sec_y   = sat_state(sec_rnd);
		sq_rnd  = (prod48 + 48'sd524288) >>> 20;
		cube    = (prod_s1 + 64'sd524288) >>> 20;
		cube_abs = cube[PROD_W-1] ? -cube : cube;
		quot    = prod_s1[MUL_W+QUOT_W-1:MUL_W];
		term    = neg_q ? -$signed({{(ACC_W-QUOT_W){1'b0}}, quot})
		                : $signed({{(ACC_W-QUOT_W){1'b0}}, quot});
		clip_y  = sat_state({{(ACC_W-STATE_W){so3[STATE_W-1]}}, so3} - term);
		out_t   = {so3[STATE_W-1], so3} + 25'sd16;
		out_sh  = out_t >>> 5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and multiplier operand selection
	always_comb begin
		state_d   = state_q;
		op_a      = '0;
		op_b      = '0;
		ready     = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = cfg.enable ? ST_FB_MUL : ST_DONE;
				end
			end
			ST_FB_MUL: begin
				op_a    = $signed({{(MUL_W-COEF_W){1'b0}}, cfg.feedback_coef});
				op_b    = {{(MUL_W-STATE_W){so3[STATE_W-1]}}, so3};
				state_d = ST_FB_ADD;
			end
			ST_FB_ADD: begin
				state_d = ST_SEC_A;
			end
			ST_SEC_A: begin
				op_a    = {{(MUL_W-STATE_W){stage_in_q[STATE_W-1]}}, stage_in_q}
				        + {{(MUL_W-STATE_W){stage_prev_q[idx_q][STATE_W-1]}},
				           stage_prev_q[idx_q]};
				op_b    = $signed({{(MUL_W-COEF_W){1'b0}}, cfg.pole_coef});
				state_d = ST_SEC_B;
			end
			ST_SEC_B: begin
				op_a    = 32'sd262144
				        - $signed({{(MUL_W-COEF_W-1){1'b0}}, cfg.pole_coef, 1'b0});
				op_b    = {{(MUL_W-STATE_W){stage_out_q[idx_q][STATE_W-1]}},
				           stage_out_q[idx_q]};
				state_d = ST_SEC_ADD;
			end
			ST_SEC_ADD: begin
				state_d = (idx_q == STAGE_IDX_W'(STAGES-1)) ? ST_CLIP_SQ : ST_SEC_A;
			end
			ST_CLIP_SQ: begin
				op_a    = {{(MUL_W-STATE_W){so3[STATE_W-1]}}, so3};
				op_b    = {{(MUL_W-STATE_W){so3[STATE_W-1]}}, so3};
				state_d = ST_CLIP_SQR;
			end
			ST_CLIP_SQR: begin
				state_d = ST_CLIP_CU;
			end
			ST_CLIP_CU: begin
				op_a    = {{(MUL_W-SQ_W){sq_q[SQ_W-1]}}, sq_q};
				op_b    = {{(MUL_W-STATE_W){so3[STATE_W-1]}}, so3};
				state_d = ST_CLIP_CUR;
			end
			ST_CLIP_CUR: begin
				state_d = ST_CLIP_DIV;
			end
			ST_CLIP_DIV: begin
				op_a    = $signed({{(MUL_W-MAG_W){1'b0}}, mag_q});
				op_b    = $signed(RECIP6);
				state_d = ST_CLIP_SUB;
			end
			ST_CLIP_SUB: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Filter state: cleared by reset, written as the sequence advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGES; i++) begin
				stage_out_q[i]  <= '0;
				stage_prev_q[i] <= '0;
			end
			idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_FB_ADD: begin
					idx_q <= '0;
				end
				ST_SEC_ADD: begin
					stage_prev_q[idx_q] <= stage_in_q;
					stage_out_q[idx_q]  <= sec_y;
					idx_q               <= idx_q + 1'b1;
				end
				ST_CLIP_SUB: begin
					stage_out_q[STAGES-1] <= clip_y;
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the sequence
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					mono_q          <= {in_sum, 4'b0000};
					res_q.left      <= left;
					res_q.right     <= right;
					res_q.processed <= 1'b0;
				end
			end
			ST_FB_ADD: begin
				stage_in_q <= x_next;
			end
			ST_SEC_B: begin
				acc_q <= prod48;
			end
			ST_SEC_ADD: begin
				stage_in_q <= sec_y;
			end
			ST_CLIP_SQR: begin
				sq_q <= sq_rnd[SQ_W-1:0];
			end
			ST_CLIP_CUR: begin
				mag_q <= cube_abs[MAG_W-1:0];
				neg_q <= cube[PROD_W-1];
			end
			ST_OUT: begin
				res_q.left      <= sat_sample(out_sh[OUT_RND_W-1:0]);
				res_q.right     <= sat_sample(out_sh[OUT_RND_W-1:0]);
				res_q.processed <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

`default_nettype wire

// File: sim/tb_ladder_lowpass_filter_unit.sv
// Self-checking testbench for the four-pole ladder low-pass filter unit.
`default_nettype none

module tb_ladder_lowpass_filter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ladlp_pkg::*;

	// Settling wait after the last result is back, before a register write
	localparam int FILTER_LATENCY = 22;
	localparam int SETTLE_CYCLES  = 2 * FILTER_LATENCY;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_REQUESTS = 155;
	// Index with no register behind it: the write must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [COEF_W-1:0]    COEF_MAX  = '1;
	localparam logic [COEF_W-1:0]    COEF_HALF = 18'd131072;

	// Predicts each stereo pair from the register settings and the section
	// state, and holds the pairs still awaited on the output channel.
	class ladder_scoreboard;
		bit     enable_on = ENABLE_RST;
		longint pole      = POLE_RST;
		longint feedback  = FEEDBACK_RST;
		longint stage_y[STAGES];
		longint stage_x[STAGES];
		res_t   awaited[$];
		int     mismatches;
		int     checked;
		int     bypassed;

		function longint round_half_up(longint v, int n);
			return (v + (64'sd1 <<< (n - 1))) >>> n;
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			hi = (64'sd1 <<< (w - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
			case (idx)
				REG_ENABLE:   enable_on = value[0];
				REG_POLE:     pole = value;
				REG_FEEDBACK: feedback = value;
				default: ;
			endcase
		endfunction

		function res_t filter_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
			res_t   res;
			longint x, y, acc, sq, cube, mix;
			res.left      = l;
			res.right     = r;
			res.processed = 1'b0;
			if (!enable_on) return res;
			// Mono in Q4.20, less the resonance term taken from the last stage
			mix = (longint'(l) + longint'(r)) * 16;
			x = clamp(mix - round_half_up(feedback * stage_y[STAGES-1], 15), STATE_W);
			for (int i = 0; i < STAGES; i++) begin
				acc = (x + stage_x[i]) * pole + ((64'sd1 <<< 18) - 2 * pole) * stage_y[i];
				y = clamp(round_half_up(acc, 18), STATE_W);
				stage_x[i] = x;
				stage_y[i] = y;
				x = y;
			end
			// Soft clip y - y^3/6, divide truncating toward zero
			y = stage_y[STAGES-1];
			sq = round_half_up(y * y, 20);
			cube = round_half_up(sq * y, 20);
			stage_y[STAGES-1] = clamp(y - cube / 6, STATE_W);
			y = clamp(round_half_up(stage_y[STAGES-1], 5), SAMPLE_W);
			res.left      = y[SAMPLE_W-1:0];
			res.right     = y[SAMPLE_W-1:0];
			res.processed = 1'b1;
			return res;
		endfunction

		function void note_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
			awaited.push_back(filter_pair(l, r));
		endfunction

		function void check_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
				logic proc);
			res_t want;
			checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result left %0d right %0d processed %0b",
					$time, l, r, proc);
				return;
			end
			want = awaited.pop_front();
			if (!want.processed) bypassed++;
			if (l !== want.left) begin
				mismatches++;
				$display("%0t: left_out expected %0d actual %0d", $time, want.left, l);
			end
			if (r !== want.right) begin
				mismatches++;
				$display("%0t: right_out expected %0d actual %0d", $time, want.right, r);
			end
			if (proc !== want.processed) begin
				mismatches++;
				$display("%0t: processed expected %0b actual %0b", $time, want.processed, proc);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ladlp_in_if  in_bus();
	ladlp_out_if out_bus();
	ladlp_cfg_if cfg_bus();

	ladder_scoreboard sb = new;

	// Idling odds, one for each side: 0 disables idling on that side
	int gap_odds;
	int stall_odds;
	// The stimulus asks for a long output hold-off by bumping hold_asks
	int hold_asks;
	int requests_sent;
	int settings_used;
	int cfg_writes;

	ladder_lowpass_filter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus),
		.cfg_ch (cfg_bus)
	);

	always #5 clk = ~clk;

	// Drive every input to a known value before the first edge
	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		in_bus.valid    = 1'b0;
		in_bus.left_in  = '0;
		in_bus.right_in = '0;
		out_bus.ready   = 1'b0;
		cfg_bus.valid   = 1'b0;
		cfg_bus.index   = REG_ENABLE;
		cfg_bus.data    = '0;
		gap_odds        = 0;
		stall_odds      = 0;
		hold_asks       = 0;
		requests_sent   = 0;
		settings_used   = 0;
		cfg_writes      = 0;
	end

	// Offer one pair, perhaps after an idle burst; valid stays high afterwards
	task automatic offer_pair(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_bus.valid    <= 1'b1;
		in_bus.left_in  <= l;
		in_bus.right_in <= r;
		do @(posedge clk); while (!in_bus.ready);
		sb.note_pair(l, r);
		requests_sent++;
	endtask

	// Write one register; the caller lowers valid once its writes are done
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.set_reg(idx, value);
		cfg_writes++;
	endtask

	task automatic apply_setting(input logic [COEF_W-1:0] en_word,
			input logic [COEF_W-1:0] pole_word, input logic [COEF_W-1:0] fb_word);
		write_reg(REG_ENABLE, en_word);
		write_reg(REG_POLE, pole_word);
		write_reg(REG_FEEDBACK, fb_word);
		cfg_bus.valid <= 1'b0;
		settings_used++;
	endtask

	// Hold the input until every awaited pair is back and the sequencer is quiet
	task automatic drain();
		in_bus.valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mix of full-scale noise, quiet signal and the corners of the sample range
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5:       v = $urandom_range(0, 1023) - 512;
			6, 7:       v = $urandom_range(0, 16383) - 8192;
			8:          v = $urandom_range(0, 1) ? 32767 : -32768;
			default:    v = $urandom_range(0, 4) - 2;
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	// Output side: check each accepted request, then decide ready for the next edge
	initial begin : output_side
		int stall_left;
		int hold_left;
		int hold_seen;
		stall_left = 0;
		hold_left  = 0;
		hold_seen  = 0;
		forever begin
			@(posedge clk);
			if (out_bus.valid && out_bus.ready) begin
				sb.check_pair(out_bus.left_out, out_bus.right_out, out_bus.processed);
			end
			if (hold_seen != hold_asks) begin
				hold_seen++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				// Long hold-off: the unit fills and must stall its input
				hold_left--;
				out_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_bus.ready <= 1'b0;
			end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int odds_menu[4];
		logic [COEF_W-1:0] en_word, pole_word, fb_word;
		logic signed [SAMPLE_W-1:0] l, r;
		odds_menu = '{0, 3, 6, 12};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		gap_odds   <= 4;
		stall_odds <= 4;

		// Reset settings: full-scale steps, opposite rails, smallest steps
		offer_pair(0, 0);
		offer_pair(32767, 32767);
		offer_pair(32767, 32767);
		offer_pair(-32768, -32768);
		offer_pair(-32768, -32768);
		offer_pair(32767, -32768);
		offer_pair(1, 1);
		offer_pair(-1, -1);
		offer_pair(-32768, 32767);
		offer_pair(16384, -1);
		drain();

		// Enable written with upper bits set: only bit 0 counts, so bypass.
		// A write to the spare index must change nothing.
		write_reg(REG_ENABLE, 18'h3FFFE);
		write_reg(REG_SPARE, 18'h3FFFF);
		cfg_bus.valid <= 1'b0;
		settings_used++;
		offer_pair(32767, -32768);
		offer_pair(-32768, 32767);
		offer_pair(0, -1);
		offer_pair(1, 0);
		drain();

		// Zero pole: every section holds its output
		apply_setting(18'd1, 18'd0, 18'd0);
		offer_pair(32767, 32767);
		offer_pair(-32768, -32768);
		offer_pair(0, 0);
		drain();

		// Largest pole with feedback above four: drives the state into saturation
		apply_setting(18'd1, COEF_MAX, COEF_MAX);
		offer_pair(32767, 32767);
		offer_pair(-32768, -32768);
		offer_pair(32767, 32767);
		offer_pair(0, 0);
		drain();

		// Half pole with gain four
		apply_setting(18'd1, COEF_HALF, COEF_HALF);
		offer_pair(32767, 32767);
		offer_pair(-32768, -32768);
		offer_pair(32767, -32768);
		offer_pair(0, 0);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			en_word = {17'd0, 1'($urandom_range(0, 4) != 0)};
			if ($urandom_range(0, 2) == 0) en_word[COEF_W-1:1] = 17'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: pole_word = 18'($urandom_range(1000, 90000));
				6, 7:             pole_word = 18'($urandom);
				8:                pole_word = $urandom_range(0, 1) ? COEF_MAX : 18'd0;
				default:          pole_word = COEF_HALF;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: fb_word = 18'($urandom_range(0, 131072));
				5, 6:          fb_word = 18'd0;
				7:             fb_word = COEF_HALF;
				default:       fb_word = 18'($urandom);
			endcase
			apply_setting(en_word, pole_word, fb_word);

			// Vary the idling per phase; the last phase runs flat out
			if (ph == RANDOM_PHASES - 1) begin
				gap_odds   <= 0;
				stall_odds <= 0;
			end else begin
				gap_odds   <= odds_menu[$urandom_range(0, 3)];
				stall_odds <= odds_menu[$urandom_range(0, 3)];
			end

			for (int k = 0; k < PHASE_REQUESTS; k++) begin
				if ((ph == 3 || ph == 8) && k == 40) hold_asks <= hold_asks + 1;
				l = pick_sample();
				case ($urandom_range(0, 5))
					0:       r = l;
					1:       r = -l;
					default: r = pick_sample();
				endcase
				offer_pair(l, r);
			end
			drain();
		end

		$display("Run covered %0d stereo requests under %0d register settings (%0d writes),",
			requests_sent, settings_used, cfg_writes);
		$display("%0d results checked, %0d bypassed, %0d long output hold-offs, %0d mismatches.",
			sb.checked, sb.bypassed, hold_asks, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin : watchdog
		#10ms;
		$display("Timeout with %0d results still awaited", sb.awaited.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
